// File: rtl/aoc_pkg.sv
// Shared types, constants and saturation helper for the accelerometer offset calibration block
`timescale 1ns / 1ps
package aoc_pkg;

	localparam int CAL_SAMPLES_LOG2_DEF = 9;
	localparam int SAMPLE_W = 16;
	localparam int ONE_G_W = 14;
	localparam logic [ONE_G_W-1:0] ONE_G_RESET = 14'd255;

	// run position of the beat being accepted
	typedef struct packed {
		logic cal;
		logic first;
		logic last;
	} aoc_ctl_t;

	// clamp an 18-bit signed value to 16 bits
	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [17:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/aoc_seq.sv
// Calibration run sequencer: counts samples left in the run and flags first and last
`timescale 1ns / 1ps
module aoc_seq #(
	parameter int CAL_SAMPLES_LOG2 = aoc_pkg::CAL_SAMPLES_LOG2_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             start,
	output aoc_pkg::aoc_ctl_t ctl
);
	import aoc_pkg::*;

	localparam int CW = CAL_SAMPLES_LOG2 + 1;
	localparam logic [CW-1:0] FULL = CW'(1) << CAL_SAMPLES_LOG2;

	logic [CW-1:0] left_q;
	logic [CW-1:0] eff;

	// restart the run on a start flag
	always_comb begin
		eff = start ? FULL : left_q;
		ctl.cal = (eff != '0);
		ctl.first = (eff == FULL);
		ctl.last = (eff == CW'(1));
	end

	// count down once per accepted beat while a run is on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= FULL;
		end else if (accept) begin
			left_q <= ctl.cal ? eff - CW'(1) : eff;
		end
	end

endmodule

// File: rtl/aoc_lane.sv
// One axis lane: running sum, offset register and corrected output register
`timescale 1ns / 1ps
module aoc_lane #(
	parameter int CAL_SAMPLES_LOG2 = aoc_pkg::CAL_SAMPLES_LOG2_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv_in,
	input  logic                                   adv_out,
	input  aoc_pkg::aoc_ctl_t                      ctl_in,
	input  aoc_pkg::aoc_ctl_t                      ctl_s1,
	input  logic signed [aoc_pkg::SAMPLE_W-1:0]    sample,
	input  logic [aoc_pkg::ONE_G_W-1:0]            trim,
	output logic signed [aoc_pkg::SAMPLE_W-1:0]    corrected_s2
);
	import aoc_pkg::*;

	localparam int SW = SAMPLE_W + CAL_SAMPLES_LOG2;
	localparam logic signed [SW:0] HALF = (SW+1)'(1) << (CAL_SAMPLES_LOG2 - 1);

	logic signed [SW-1:0]       sum_q;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [SAMPLE_W-1:0] offset_q;

	logic signed [SW:0]         rounded;
	logic signed [SW:0]         shifted;
	logic signed [17:0]         avg_trim;
	logic signed [SAMPLE_W-1:0] new_offset;
	logic signed [SAMPLE_W-1:0] result;

	// accumulate; restart from the sample on the first beat of a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (adv_in && ctl_in.cal) begin
			if (ctl_in.first) begin
				sum_q <= SW'(sample);
			end else begin
				sum_q <= sum_q + SW'(sample);
			end
		end
	end

	// hold the sample for the output stage
	always_ff @(posedge clk) begin
		if (adv_in) begin
			sample_s1 <= sample;
		end
	end

	// rounded average minus trim, then the output value
	always_comb begin
		rounded = {sum_q[SW-1], sum_q} + HALF;
		shifted = rounded >>> CAL_SAMPLES_LOG2;
		avg_trim = {shifted[16], shifted[16:0]} - $signed({4'b0, trim});
		new_offset = sat16(avg_trim);
		if (!ctl_s1.cal) begin
			result = sat16(18'(sample_s1) - 18'(offset_q));
		end else if (ctl_s1.last) begin
			result = sat16(-18'(new_offset));
		end else begin
			result = '0;
		end
	end

	// offsets read as zero during a run and take the rounded average minus trim on its last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (adv_out && ctl_s1.cal) begin
			offset_q <= ctl_s1.last ? new_offset : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			corrected_s2 <= result;
		end
	end

endmodule

// File: rtl/accel_offset_calibration_unit.sv
// Top level: stream ports, one_g register, sequencer, three axis lanes and output merge
`timescale 1ns / 1ps
// Accelerometer zero-offset calibration.
// Slave stream: one oriented three-axis sample per beat; tuser set restarts a
// calibration run of 2^CAL_SAMPLES_LOG2 samples with that beat.
// Master stream: one beat per input beat, in order, holding each axis minus
// its offset saturated to 16 bits, with tuser set while the beat belonged to
// a run. Run beats output zero, except the last, which outputs the negated
// new offsets.
// Configuration: cfg_we writes one_g (counts per g, taken off the Z offset)
// at any clock edge; write it only while the block is idle.
// Each input beat passes through one stage for the running sums and the run
// counter, then one for offset and correction into the output register.
// Throughput is one beat per cycle unless the receiver stalls; each axis has
// its own lane of adders, so the three axes run side by side.
// Reset starts a calibration run and sets one_g to 255. When the receiver
// stalls the output register holds its beat, the middle stage fills, and
// s_axis_tready then drops until the output beat is taken.
module accel_offset_calibration_unit #(
	parameter int CAL_SAMPLES_LOG2 = aoc_pkg::CAL_SAMPLES_LOG2_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [47:0]                  s_axis_tdata,  // accel_x, accel_y, accel_z
	input  logic                         s_axis_tuser,  // start_calibration
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [47:0]                  m_axis_tdata,  // corrected_x, corrected_y, corrected_z
	output logic                         m_axis_tuser,  // calibrating
	input  logic                         cfg_we,
	input  logic [aoc_pkg::ONE_G_W-1:0]  cfg_wdata
);
	import aoc_pkg::*;

	logic [ONE_G_W-1:0] one_g_q;
	logic               valid_s1;
	logic               valid_s2;
	aoc_ctl_t           ctl_in;
	aoc_ctl_t           ctl_s1;
	logic               cal_s2;
	logic               adv_out;
	logic               adv_in;
	logic signed [SAMPLE_W-1:0] corr_x;
	logic signed [SAMPLE_W-1:0] corr_y;
	logic signed [SAMPLE_W-1:0] corr_z;

	// advance when the stage ahead is free or moving
	assign adv_out = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || !valid_s2 || m_axis_tready;
	assign adv_in = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_g_q <= ONE_G_RESET;
		end else if (cfg_we) begin
			one_g_q <= cfg_wdata;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_out) begin
				valid_s1 <= 1'b0;
			end
			if (adv_out) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_in) begin
			ctl_s1 <= ctl_in;
		end
		if (adv_out) begin
			cal_s2 <= ctl_s1.cal;
		end
	end

	aoc_seq #(.CAL_SAMPLES_LOG2(CAL_SAMPLES_LOG2)) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (adv_in),
		.start  (s_axis_tuser),
		.ctl    (ctl_in)
	);

	aoc_lane #(.CAL_SAMPLES_LOG2(CAL_SAMPLES_LOG2)) u_lane_x (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv_in       (adv_in),
		.adv_out      (adv_out),
		.ctl_in       (ctl_in),
		.ctl_s1       (ctl_s1),
		.sample       (s_axis_tdata[15:0]),
		.trim         ('0),
		.corrected_s2 (corr_x)
	);

	aoc_lane #(.CAL_SAMPLES_LOG2(CAL_SAMPLES_LOG2)) u_lane_y (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv_in       (adv_in),
		.adv_out      (adv_out),
		.ctl_in       (ctl_in),
		.ctl_s1       (ctl_s1),
		.sample       (s_axis_tdata[31:16]),
		.trim         ('0),
		.corrected_s2 (corr_y)
	);

	aoc_lane #(.CAL_SAMPLES_LOG2(CAL_SAMPLES_LOG2)) u_lane_z (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv_in       (adv_in),
		.adv_out      (adv_out),
		.ctl_in       (ctl_in),
		.ctl_s1       (ctl_s1),
		.sample       (s_axis_tdata[47:32]),
		.trim         (one_g_q),
		.corrected_s2 (corr_z)
	);

	// merge the lanes into the output beat
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {corr_z, corr_y, corr_x};
	assign m_axis_tuser = cal_s2;

endmodule
